>>> rtl/clws_pkg.sv
// Shared types and constants for the character display write sequencer.
// No dependencies; used by the channel interfaces and the top level.
package clws_pkg;

	localparam int WAIT_COUNT_BITS_DEF = 16;
	localparam int CFG_DATA_BITS       = 16;
	localparam int CFG_INDEX_BITS      = 3;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_POWER  = 3'd1,
		PH_SETUP  = 3'd2,
		PH_PULSE  = 3'd3,
		PH_SETTLE = 3'd4,
		PH_EXTRA  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_DATA   = 3'd1,
		ACT_CMD    = 3'd2,
		ACT_CURSOR = 3'd3,
		ACT_INIT   = 3'd4,
		ACT_CLEAR  = 3'd5
	} action_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SETUP        = 3'd0,
		CFG_PULSE        = 3'd1,
		CFG_SETTLE       = 3'd2,
		CFG_CURSOR_EXTRA = 3'd3,
		CFG_CLEAR_EXTRA  = 3'd4,
		CFG_POWER_UP     = 3'd5,
		CFG_INIT_EXTRA   = 3'd6
	} cfg_idx_t;

	localparam logic [7:0]  SETUP_RST        = 8'd2;
	localparam logic [7:0]  PULSE_RST        = 8'd2;
	localparam logic [15:0] SETTLE_RST       = 16'd45;
	localparam logic [15:0] CURSOR_EXTRA_RST = 16'd100;
	localparam logic [15:0] CLEAR_EXTRA_RST  = 16'd2000;
	localparam logic [15:0] POWER_UP_RST     = 16'd50000;
	localparam logic [15:0] INIT_EXTRA_RST   = 16'd5000;

	localparam logic [7:0] CMD_CLEAR       = 8'h01;
	localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
	localparam logic [7:0] LINE2_BASE      = 8'h40;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_value;
		logic       line_select;
		logic [5:0] column;
	} req_t;

	typedef struct packed {
		logic       rs_level;
		logic       enable_level;
		logic [7:0] data_bus;
		logic       busy_res;
		logic       rejected;
	} res_t;

	// power-on command list: function set, display on, clear, entry mode
	function automatic logic [7:0] init_cmd(input logic [1:0] k);
		logic [7:0] c;
		unique case (k)
			2'd0: c = 8'h38;
			2'd1: c = 8'h0C;
			2'd2: c = 8'h01;
			default: c = 8'h06;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/clws_req_if.sv
// Request channel: valid/ready handshake carrying one clws_pkg::req_t word.
// Depends on clws_pkg.
interface clws_req_if;
	logic           valid;
	logic           ready;
	clws_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/clws_res_if.sv
// Result channel: valid/ready handshake carrying one clws_pkg::res_t word.
// Depends on clws_pkg.
interface clws_res_if;
	logic           valid;
	logic           ready;
	clws_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/char_lcd_write_sequencer.sv
// Character display write sequencer, 8-bit parallel bus, one result word per request word.
// A result word is registered, valid in the cycle after its request word is accepted.
// Throughput: one word per cycle while results drain; the state update and pin levels
// for a word are computed in one pass from the state registers into the result register.
// Reset (arst_n low) returns to idle with pins low and timing registers at defaults.
// Depends on clws_pkg, clws_req_if, clws_res_if.
module char_lcd_write_sequencer #(
	parameter int WAIT_COUNT_BITS = clws_pkg::WAIT_COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	clws_req_if.sink                            req,
	clws_res_if.source                          res,
	input  logic                                cfg_we,
	input  logic [clws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [clws_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import clws_pkg::*;

	localparam int W = WAIT_COUNT_BITS;

	// timing registers
	logic [7:0]  setup_q, pulse_q;
	logic [15:0] settle_q, cursor_extra_q, clear_extra_q, power_up_q, init_extra_q;

	// sequencer state
	phase_t      phase_q, phase_d;
	logic [W-1:0] cnt_q, cnt_d;
	logic [7:0]  byte_q, byte_d;
	logic        sel_q, sel_d;
	logic        en_q, en_d;
	logic [15:0] extra_q, extra_d;
	logic [2:0]  idx_q, idx_d;
	logic        rej_d;

	res_t        res_d, res_data_q;
	logic        res_valid_q;
	logic        acc;

	assign req.ready = !res_valid_q || res.ready;
	assign acc       = req.valid && req.ready;
	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q        <= SETUP_RST;
			pulse_q        <= PULSE_RST;
			settle_q       <= SETTLE_RST;
			cursor_extra_q <= CURSOR_EXTRA_RST;
			clear_extra_q  <= CLEAR_EXTRA_RST;
			power_up_q     <= POWER_UP_RST;
			init_extra_q   <= INIT_EXTRA_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SETUP:        setup_q        <= cfg_data[7:0];
				CFG_PULSE:        pulse_q        <= cfg_data[7:0];
				CFG_SETTLE:       settle_q       <= cfg_data;
				CFG_CURSOR_EXTRA: cursor_extra_q <= cfg_data;
				CFG_CLEAR_EXTRA:  clear_extra_q  <= cfg_data;
				CFG_POWER_UP:     power_up_q     <= cfg_data;
				CFG_INIT_EXTRA:   init_extra_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state: apply the word, then run through zero-length phases.
	// A pulse phase is never empty, so four passes always reach a waiting phase.
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		byte_d  = byte_q;
		sel_d   = sel_q;
		en_d    = en_q;
		extra_d = extra_q;
		idx_d   = idx_q;
		rej_d   = 1'b0;

		unique case (req.data.action)
			ACT_TICK: begin
				if (phase_q != PH_IDLE && cnt_q != '0)
					cnt_d = cnt_q - W'(1);
			end
			ACT_DATA, ACT_CMD, ACT_CURSOR, ACT_INIT, ACT_CLEAR: begin
				if (phase_q != PH_IDLE) begin
					rej_d = 1'b1;
				end else begin
					idx_d   = 3'd0;
					en_d    = 1'b0;
					phase_d = PH_SETUP;
					cnt_d   = W'(setup_q);
					unique case (req.data.action)
						ACT_DATA: begin
							sel_d   = 1'b1;
							byte_d  = req.data.byte_value;
							extra_d = 16'd0;
						end
						ACT_CMD: begin
							sel_d   = 1'b0;
							byte_d  = req.data.byte_value;
							extra_d = 16'd0;
						end
						ACT_CURSOR: begin
							sel_d   = 1'b0;
							byte_d  = CMD_SET_DDRAM
								+ (req.data.line_select ? LINE2_BASE : 8'd0)
								+ {2'b00, req.data.column};
							extra_d = cursor_extra_q;
						end
						ACT_INIT: begin
							phase_d = PH_POWER;
							cnt_d   = W'(power_up_q);
						end
						default: begin
							sel_d   = 1'b0;
							byte_d  = CMD_CLEAR;
							extra_d = clear_extra_q;
						end
					endcase
				end
			end
			default: ;
		endcase

		for (int i = 0; i < 4; i++) begin
			if (phase_d != PH_IDLE && cnt_d == '0) begin
				unique case (phase_d)
					PH_POWER: begin
						idx_d   = 3'd1;
						sel_d   = 1'b0;
						byte_d  = init_cmd(2'd0);
						extra_d = init_extra_q;
						en_d    = 1'b0;
						phase_d = PH_SETUP;
						cnt_d   = W'(setup_q);
					end
					PH_SETUP: begin
						en_d    = 1'b1;
						phase_d = PH_PULSE;
						cnt_d   = (pulse_q == 8'd0) ? W'(1) : W'(pulse_q);
					end
					PH_PULSE: begin
						en_d    = 1'b0;
						phase_d = PH_SETTLE;
						cnt_d   = W'(settle_q);
					end
					PH_SETTLE: begin
						phase_d = PH_EXTRA;
						cnt_d   = W'(extra_d);
					end
					default: begin
						if (idx_d >= 3'd1 && idx_d <= 3'd3) begin
							byte_d  = init_cmd(idx_d[1:0]);
							idx_d   = idx_d + 3'd1;
							sel_d   = 1'b0;
							extra_d = init_extra_q;
							en_d    = 1'b0;
							phase_d = PH_SETUP;
							cnt_d   = W'(setup_q);
						end else begin
							idx_d   = 3'd0;
							phase_d = PH_IDLE;
							cnt_d   = '0;
						end
					end
				endcase
			end
		end
	end

	// result word: pin levels after the word is applied
	always_comb begin
		res_d.rs_level     = sel_d;
		res_d.enable_level = en_d;
		res_d.data_bus     = byte_d;
		res_d.busy_res     = (phase_d != PH_IDLE);
		res_d.rejected     = rej_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			byte_q  <= 8'd0;
			sel_q   <= 1'b0;
			en_q    <= 1'b0;
			extra_q <= 16'd0;
			idx_q   <= 3'd0;
		end else if (acc) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			byte_q  <= byte_d;
			sel_q   <= sel_d;
			en_q    <= en_d;
			extra_q <= extra_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (acc)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc)
			res_data_q <= res_d;
	end

	// E is only ever high during the pulse phase
	a_en_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		en_q |-> phase_q == PH_PULSE)
		else $error("enable high outside pulse phase");

	// empty phases are always skipped, so a busy sequencer has time left
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> cnt_q != '0)
		else $error("busy with zero wait count");

	// init command index only runs while a write is in flight
	a_init_idx: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> (phase_q != PH_IDLE && phase_q != PH_POWER))
		else $error("init index set outside an init write");

	// a rejected request leaves the sequencer busy
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_data_q.rejected |-> res_data_q.busy_res)
		else $error("rejected word reports idle");

	// a rejected request does not change the sequencer state
	a_rej_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && rej_d |=> phase_q == $past(phase_q) && cnt_q == $past(cnt_q))
		else $error("rejected request changed state");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for char_lcd_write_sequencer: predicts the display pin levels for every
// request or tick word and compares each result word. Depends on clws_pkg, clws_req_if,
// clws_res_if and the block itself.
module testbench;
	import clws_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 100_000;
	localparam logic [2:0] ACT_UNUSED_A = 3'd6;
	localparam logic [2:0] ACT_UNUSED_B = 3'd7;
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

	typedef struct {
		phase_t      phase;
		logic [15:0] wait_count;
		logic [7:0]  held_byte;
		logic        held_select;
		logic        enable;
		logic [15:0] extra_wait;
		int unsigned init_index;
	} seq_state_t;

	typedef struct {
		logic [7:0]  setup;
		logic [7:0]  pulse;
		logic [15:0] settle;
		logic [15:0] cursor_extra;
		logic [15:0] clear_extra;
		logic [15:0] power_up;
		logic [15:0] init_extra;
	} timing_t;

	// Tracks the sequencer state and the pin words it must produce.
	class lcd_pin_tracker;
		seq_state_t  cur;
		timing_t     tim;
		res_t        pin_queue[$];
		logic [7:0]  boot_cmds[4];
		int          errors;
		int          checked;
		int          started;
		int          refused;

		function new();
			cur.phase       = PH_IDLE;
			cur.wait_count  = '0;
			cur.held_byte   = '0;
			cur.held_select = 1'b0;
			cur.enable      = 1'b0;
			cur.extra_wait  = '0;
			cur.init_index  = 0;
			tim.setup        = SETUP_RST;
			tim.pulse        = PULSE_RST;
			tim.settle       = SETTLE_RST;
			tim.cursor_extra = CURSOR_EXTRA_RST;
			tim.clear_extra  = CLEAR_EXTRA_RST;
			tim.power_up     = POWER_UP_RST;
			tim.init_extra   = INIT_EXTRA_RST;
			boot_cmds = '{CMD_FUNCTION_SET, CMD_DISPLAY_ON, CMD_CLEAR, CMD_ENTRY_MODE};
			errors  = 0;
			checked = 0;
			started = 0;
			refused = 0;
		endfunction

		function void load_write(logic sel, logic [7:0] b, logic [15:0] extra);
			cur.held_select = sel;
			cur.held_byte   = b;
			cur.extra_wait  = extra;
			cur.enable      = 1'b0;
			cur.phase       = PH_SETUP;
			cur.wait_count  = 16'(tim.setup);
		endfunction

		function void next_phase();
			int unsigned k;
			case (cur.phase)
				PH_POWER: begin
					cur.init_index = 1;
					load_write(1'b0, boot_cmds[0], tim.init_extra);
				end
				PH_SETUP: begin
					cur.enable     = 1'b1;
					cur.phase      = PH_PULSE;
					// a zero pulse length still gives a one-tick strobe
					cur.wait_count = (tim.pulse == '0) ? 16'd1 : 16'(tim.pulse);
				end
				PH_PULSE: begin
					cur.enable     = 1'b0;
					cur.phase      = PH_SETTLE;
					cur.wait_count = tim.settle;
				end
				PH_SETTLE: begin
					cur.phase      = PH_EXTRA;
					cur.wait_count = cur.extra_wait;
				end
				default: begin
					if (cur.init_index >= 1 && cur.init_index <= 3) begin
						k = cur.init_index;
						cur.init_index++;
						load_write(1'b0, boot_cmds[k], tim.init_extra);
					end else begin
						cur.init_index = 0;
						cur.phase      = PH_IDLE;
						cur.wait_count = '0;
					end
				end
			endcase
		endfunction

		function void skip_empty();
			while (cur.phase != PH_IDLE && cur.wait_count == '0)
				next_phase();
		endfunction

		function res_t apply_word(req_t w);
			res_t r;
			logic rej;
			rej = 1'b0;
			if (w.action == ACT_TICK) begin
				if (cur.phase != PH_IDLE) begin
					if (cur.wait_count != '0)
						cur.wait_count--;
					skip_empty();
				end
			end else if (w.action <= ACT_CLEAR) begin
				if (cur.phase != PH_IDLE) begin
					rej = 1'b1;
				end else begin
					cur.init_index = 0;
					case (w.action)
						ACT_DATA: load_write(1'b1, w.byte_value, '0);
						ACT_CMD:  load_write(1'b0, w.byte_value, '0);
						ACT_CURSOR: load_write(1'b0, CMD_SET_DDRAM
							+ (w.line_select ? LINE2_BASE : 8'h00) + {2'b00, w.column},
							tim.cursor_extra);
						ACT_INIT: begin
							cur.enable     = 1'b0;
							cur.phase      = PH_POWER;
							cur.wait_count = tim.power_up;
						end
						default: load_write(1'b0, CMD_CLEAR, tim.clear_extra);
					endcase
					skip_empty();
				end
			end
			r.rs_level     = cur.held_select;
			r.enable_level = cur.enable;
			r.data_bus     = cur.held_byte;
			r.busy_res     = (cur.phase != PH_IDLE);
			r.rejected     = rej;
			return r;
		endfunction

		function void note_request(req_t w);
			res_t r;
			r = apply_word(w);
			if (r.rejected)
				refused++;
			else if (w.action != ACT_TICK && w.action <= ACT_CLEAR)
				started++;
			pin_queue.push_back(r);
		endfunction

		// ticks still needed before the sequencer is back at idle
		function int unsigned ticks_to_idle();
			seq_state_t  saved;
			req_t        t;
			int unsigned n;
			saved    = cur;
			t        = '0;
			t.action = ACT_TICK;
			n        = 0;
			while (cur.phase != PH_IDLE) begin
				void'(apply_word(t));
				n++;
			end
			cur = saved;
			return n;
		endfunction

		task report(input string what);
			errors++;
			if (errors <= 30)
				$display("ERROR: %s", what);
		endtask

		task check_pins(input res_t got);
			res_t want;
			if (pin_queue.size() == 0) begin
				report("result word arrived with nothing expected");
				return;
			end
			want = pin_queue.pop_front();
			checked++;
			if (got.rs_level !== want.rs_level)
				report($sformatf("word %0d rs_level %b, want %b", checked,
					got.rs_level, want.rs_level));
			if (got.enable_level !== want.enable_level)
				report($sformatf("word %0d enable_level %b, want %b", checked,
					got.enable_level, want.enable_level));
			if (got.data_bus !== want.data_bus)
				report($sformatf("word %0d data_bus %h, want %h", checked,
					got.data_bus, want.data_bus));
			if (got.busy_res !== want.busy_res)
				report($sformatf("word %0d busy_res %b, want %b", checked,
					got.busy_res, want.busy_res));
			if (got.rejected !== want.rejected)
				report($sformatf("word %0d rejected %b, want %b", checked,
					got.rejected, want.rejected));
		endtask
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int                        send_gap_pct;
	int                        recv_gap_pct;
	bit                        hold_req;
	int                        hold_left;
	int unsigned               cycle_count;
	int                        settings_used;
	lcd_pin_tracker            sb;

	clws_req_if req_if ();
	clws_res_if res_if ();

	char_lcd_write_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready)
				sb.check_pins(res_if.data);
			if (req_if.valid && req_if.ready)
				sb.note_request(req_if.data);
		end
	end

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic req_t make_word(logic [2:0] act, logic [7:0] b, logic l, logic [5:0] c);
		req_t w;
		w.action      = act;
		w.byte_value  = b;
		w.line_select = l;
		w.column      = c;
		return w;
	endfunction

	function automatic req_t random_request();
		return make_word(3'($urandom_range(ACT_CLEAR, ACT_DATA)), 8'($urandom),
			1'($urandom), 6'($urandom));
	endfunction

	function automatic req_t random_word();
		req_t w;
		int   r;
		w = random_request();
		r = $urandom_range(99);
		if (r < 3)
			w.action = $urandom_range(1) ? ACT_UNUSED_A : ACT_UNUSED_B;
		else if (r >= 16)
			w.action = ACT_TICK;
		return w;
	endfunction

	function automatic int short_count(int hi);
		return ($urandom_range(7) == 0) ? 0 : $urandom_range(hi);
	endfunction

	task automatic send_word(input req_t w);
		while ($urandom_range(99) < send_gap_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= w;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	task automatic wait_pins_drained();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pin_queue.size() != 0)
			@(posedge clk);
	endtask

	// feed exactly enough ticks to finish the running sequence; stray requests
	// land while busy and must be refused
	task automatic tick_until_idle();
		int unsigned n;
		req_t        t;
		wait_pins_drained();
		n = sb.ticks_to_idle();
		repeat (n) begin
			if ($urandom_range(199) == 0)
				send_word(random_request());
			t        = random_word();
			t.action = ACT_TICK;
			send_word(t);
		end
		wait_pins_drained();
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic apply_timing(input logic [7:0] setup, input logic [7:0] pulse,
		input logic [15:0] settle, input logic [15:0] cursor, input logic [15:0] clear,
		input logic [15:0] power, input logic [15:0] boot);
		// upper byte of an 8-bit register is junk the block must drop
		write_reg(CFG_SETUP, {8'($urandom), setup});
		write_reg(CFG_PULSE, {8'($urandom), pulse});
		write_reg(CFG_SETTLE, settle);
		write_reg(CFG_CURSOR_EXTRA, cursor);
		write_reg(CFG_CLEAR_EXTRA, clear);
		write_reg(CFG_POWER_UP, power);
		write_reg(CFG_INIT_EXTRA, boot);
		cfg_we <= 1'b0;
		sb.tim.setup        = setup;
		sb.tim.pulse        = pulse;
		sb.tim.settle       = settle;
		sb.tim.cursor_extra = cursor;
		sb.tim.clear_extra  = clear;
		sb.tim.power_up     = power;
		sb.tim.init_extra   = boot;
		settings_used++;
	endtask

	task automatic random_mode(input int send_pct, input int recv_pct, input bit pressure);
		int   blk;
		int   done;
		req_t w;
		send_gap_pct = send_pct;
		recv_gap_pct = recv_pct;
		for (blk = 0; blk < 4; blk++) begin
			tick_until_idle();
			apply_timing(8'(short_count(3)), 8'(short_count(3)), 16'(short_count(6)),
				16'(short_count(8)), 16'(short_count(8)), 16'(short_count(12)),
				16'(short_count(4)));
			if (pressure && blk == 0) begin
				@(negedge clk);
				hold_req = 1'b1;
				@(posedge clk);
			end
			done = 0;
			while (done < 60) begin
				w = random_word();
				send_word(w);
				if (w.action <= ACT_CLEAR)
					done++;
			end
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.data   = '0;
		res_if.ready  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SETUP;
		cfg_data      = '0;
		hold_req      = 1'b0;
		hold_left     = 0;
		cycle_count   = 0;
		settings_used = 1;
		send_gap_pct  = 23;
		recv_gap_pct  = 81;
		sb            = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one write at the reset timing, then short timings
		send_word(make_word(ACT_DATA, 8'hFF, 1'b1, 6'h3F));
		tick_until_idle();
		apply_timing(8'd1, 8'd0, 16'd3, 16'd4, 16'd6, 16'd8, 16'd2);
		send_word(make_word(ACT_TICK, 8'hFF, 1'b1, 6'h3F));
		send_word(make_word(ACT_UNUSED_A, 8'hA5, 1'b0, 6'h2A));
		send_word(make_word(ACT_UNUSED_B, 8'h5A, 1'b1, 6'h15));
		send_word(make_word(ACT_DATA, 8'h00, 1'b0, 6'h00));
		send_word(make_word(ACT_CMD, 8'hC3, 1'b0, 6'h00));
		tick_until_idle();
		send_word(make_word(ACT_CMD, 8'hA5, 1'b1, 6'h2A));
		tick_until_idle();
		send_word(make_word(ACT_CURSOR, 8'h00, 1'b0, 6'h00));
		tick_until_idle();
		send_word(make_word(ACT_CURSOR, 8'hFF, 1'b1, 6'h3F));
		tick_until_idle();
		send_word(make_word(ACT_CLEAR, 8'h3C, 1'b0, 6'h11));
		send_word(make_word(ACT_DATA, 8'h41, 1'b0, 6'h00));
		send_word(make_word(ACT_INIT, 8'h00, 1'b1, 6'h01));
		send_word(make_word(ACT_UNUSED_B, 8'hFF, 1'b1, 6'h3F));
		tick_until_idle();
		send_word(make_word(ACT_INIT, 8'h00, 1'b0, 6'h00));
		send_word(make_word(ACT_CURSOR, 8'h12, 1'b1, 6'h05));
		send_word(make_word(ACT_CLEAR, 8'h00, 1'b0, 6'h00));
		tick_until_idle();
		// all lengths zero: every phase but the strobe is skipped at once
		apply_timing(8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_word(make_word(ACT_INIT, 8'h00, 1'b0, 6'h00));
		tick_until_idle();
		send_word(make_word(ACT_DATA, 8'h5A, 1'b0, 6'h00));
		tick_until_idle();
		send_word(make_word(ACT_CURSOR, 8'h00, 1'b1, 6'h20));
		tick_until_idle();

		random_mode(23, 81, 1'b0);
		random_mode(81, 23, 1'b0);
		random_mode(0, 0, 1'b1);

		// longest setup and strobe the 8-bit registers allow
		tick_until_idle();
		apply_timing(8'hFF, 8'hFF, 16'd1, 16'd2, 16'd1, 16'd3, 16'd1);
		send_word(make_word(ACT_CLEAR, 8'h00, 1'b0, 6'h00));
		tick_until_idle();

		repeat (8) @(posedge clk);
		if (sb.pin_queue.size() != 0)
			sb.report($sformatf("%0d expected words never arrived", sb.pin_queue.size()));
		$display("Checked %0d pin words under %0d timing settings,", sb.checked,
			settings_used);
		$display("with %0d sequences started and %0d requests refused while busy.",
			sb.started, sb.refused);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
